[hdl/hbfe_pkg.sv]
// shared types and constants for the harmonic bond force and energy block
`default_nettype none

package hbfe_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int RAND_BITS = 16;
    localparam int EPS_BITS  = 16;
    localparam int ADDR_BITS = 4;

    // register indexes, byte address is 4 * index
    typedef enum logic [1:0] {
        REG_SPRING  = 2'd0,
        REG_REST    = 2'd1,
        REG_CUTOFF  = 2'd2,
        REG_EPSILON = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] spring;
        logic [WORD_BITS-1:0] rest;
        logic [WORD_BITS-1:0] cutoff;
        logic [EPS_BITS-1:0]  epsilon;
    } cfg_t;

endpackage

`default_nettype wire

[hdl/hbfe_regs.sv]
// configuration registers behind the apb port
`default_nettype none

module hbfe_regs
    import hbfe_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output cfg_t                      cfg
);

    cfg_t       cfg_reg;
    reg_index_t idx;
    logic       wr_en;

    assign idx   = reg_index_t'(paddr[3:2]);
    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spring  <= 32'h0001_0000;
            cfg_reg.rest    <= 32'h0001_0000;
            cfg_reg.cutoff  <= '0;
            cfg_reg.epsilon <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SPRING:  cfg_reg.spring  <= pwdata;
                REG_REST:    cfg_reg.rest    <= pwdata;
                REG_CUTOFF:  cfg_reg.cutoff  <= pwdata;
                REG_EPSILON: cfg_reg.epsilon <= pwdata[EPS_BITS-1:0];
                default:     cfg_reg.spring  <= cfg_reg.spring;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (idx)
            REG_SPRING:  prdata = cfg_reg.spring;
            REG_REST:    prdata = cfg_reg.rest;
            REG_CUTOFF:  prdata = cfg_reg.cutoff;
            REG_EPSILON: prdata = {16'b0, cfg_reg.epsilon};
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/harmonic_bond_force_energy_top.sv]
// harmonic bond force and energy, fully pipelined top level
//
//  channel  dir  handshake                 payload
//  s_*      in   s_tvalid / s_tready       s_tdata: sep_x, sep_y, sep_z, rand_x, rand_y, rand_z
//  m_*      out  m_tvalid / m_tready       m_tdata: force_x/y/z, energy; m_tuser: status, saturated
//  apb      in   psel / penable / pready   spring_constant, rest_length, cutoff_length, round_epsilon
//
// one word enters per cycle while the output word is not waiting; m_tvalid rises when the word reaches the last stage
// most of the pipe is the 32 root steps and 64 quotient steps, one bit per stage
// all stages advance together; when the output word waits, the pipe holds in place
// reset clears the valid bits and loads the register defaults; no clearing pass
`default_nettype none

module harmonic_bond_force_energy_top
    import hbfe_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // sep_x, sep_y, sep_z (32 each), rand_x, rand_y, rand_z (16 each)
    input  wire logic [143:0]         s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // force_x, force_y, force_z, energy (32 each)
    output logic      [127:0]         m_tdata,
    // status, saturated
    output logic      [1:0]           m_tuser,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    localparam int SQ_STEPS = WORD_BITS;
    localparam int DV_STEPS = 2 * WORD_BITS;
    localparam int ST_SPLIT = 0;
    localparam int ST_SQUARE = 1;
    localparam int ST_SUM = 2;
    localparam int ST_SQ0 = 3;
    localparam int ST_SELECT = ST_SQ0 + SQ_STEPS;
    localparam int ST_MUL = ST_SELECT + 1;
    localparam int ST_EMUL = ST_MUL + 1;
    localparam int ST_ECOMB = ST_EMUL + 1;
    localparam int ST_DV0 = ST_ECOMB + 1;
    localparam int ST_FMUL = ST_DV0 + DV_STEPS;
    localparam int ST_FCOMB = ST_FMUL + 1;
    localparam int NST = ST_FCOMB + 1;

    typedef struct packed {
        logic [2:0]                  sneg;
        logic [2:0][WORD_BITS-1:0]   smag;
        logic [2:0]                  rneg;
        logic [2:0][RAND_BITS-1:0]   rmag;
        logic [2:0][63:0]            ssq;
        logic [2:0][31:0]            rsq;
        logic [33:0]                 sq_rem;
        logic [31:0]                 sq_root;
        logic [63:0]                 sq_rad;
        logic [33:0]                 rq_rem;
        logic [31:0]                 rq_root;
        logic [63:0]                 rq_rad;
        logic                        broken;
        logic                        drneg;
        logic [31:0]                 adr;
        logic                        force_on;
        logic [31:0]                 divisor;
        logic [2:0]                  dneg;
        logic [2:0][31:0]            dmag;
        logic [63:0]                 num;
        logic [63:0]                 adr2;
        logic [63:0]                 epl;
        logic [63:0]                 eph;
        logic [31:0]                 energy;
        logic                        esat;
        logic [31:0]                 dv_rem;
        logic [2:0][63:0]            fpl;
        logic [2:0][63:0]            fph;
        logic [2:0][31:0]            force_v;
        logic                        fsat;
    } item_t;

    cfg_t  cfg;
    item_t st_reg  [NST];
    item_t st_next [NST];
    logic  [NST-1:0] vld_reg;
    logic  en;

    hbfe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // one root bit per stage
    function automatic item_t sqrt_step(input item_t it);
        item_t       o;
        logic [35:0] t;
        logic [35:0] trial;
        o = it;
        t = {it.sq_rem, it.sq_rad[63:62]};
        trial = {2'b0, it.sq_root, 2'b01};
        if (t >= trial)
        begin
            o.sq_rem  = 34'(t - trial);
            o.sq_root = {it.sq_root[30:0], 1'b1};
        end
        else
        begin
            o.sq_rem  = t[33:0];
            o.sq_root = {it.sq_root[30:0], 1'b0};
        end
        o.sq_rad = {it.sq_rad[61:0], 2'b00};
        t = {it.rq_rem, it.rq_rad[63:62]};
        trial = {2'b0, it.rq_root, 2'b01};
        if (t >= trial)
        begin
            o.rq_rem  = 34'(t - trial);
            o.rq_root = {it.rq_root[30:0], 1'b1};
        end
        else
        begin
            o.rq_rem  = t[33:0];
            o.rq_root = {it.rq_root[30:0], 1'b0};
        end
        o.rq_rad = {it.rq_rad[61:0], 2'b00};
        return o;
    endfunction

    // one quotient bit per stage, quotient shifts into num
    function automatic item_t div_step(input item_t it);
        item_t       o;
        logic [32:0] t;
        o = it;
        t = {it.dv_rem, it.num[63]};
        if (t >= {1'b0, it.divisor})
        begin
            o.dv_rem = 32'(t - {1'b0, it.divisor});
            o.num    = {it.num[62:0], 1'b1};
        end
        else
        begin
            o.dv_rem = t[31:0];
            o.num    = {it.num[62:0], 1'b0};
        end
        return o;
    endfunction

    // stage logic
    for (genvar g = 0; g < NST; g++)
    begin : g_stage
        if (g == ST_SPLIT)
        begin : g_in
            // sign and magnitude of the input word
            always_comb
            begin
                logic [WORD_BITS-1:0] w;
                logic [RAND_BITS-1:0] rv;
                w = '0;
                rv = '0;
                st_next[g] = 'x;
                for (int i = 0; i < 3; i++)
                begin
                    w = s_tdata[i*WORD_BITS +: WORD_BITS];
                    st_next[g].sneg[i] = w[WORD_BITS-1];
                    st_next[g].smag[i] = w[WORD_BITS-1] ? (~w + 1'b1) : w;
                    rv = s_tdata[3*WORD_BITS + i*RAND_BITS +: RAND_BITS];
                    st_next[g].rneg[i] = rv[RAND_BITS-1];
                    st_next[g].rmag[i] = rv[RAND_BITS-1] ? (~rv + 1'b1) : rv;
                end
            end
        end
        else
        begin : g_work
            always_comb
            begin
                logic [95:0]          acc;
                logic [79:0]          pm;
                logic [79:0]          lim;
                logic                 fneg;
                logic [31:0]          m;
                logic                 sat;
                acc = '0;
                pm = '0;
                lim = '0;
                fneg = 1'b0;
                m = '0;
                sat = 1'b0;
                st_next[g] = st_reg[g-1];
                if (g == ST_SQUARE)
                begin
                    // squares of the magnitudes
                    for (int i = 0; i < 3; i++)
                    begin
                        st_next[g].ssq[i] = 64'(st_reg[g-1].smag[i]) *
                                            64'(st_reg[g-1].smag[i]);
                        st_next[g].rsq[i] = 32'(st_reg[g-1].rmag[i]) *
                                            32'(st_reg[g-1].rmag[i]);
                    end
                end
                else if (g == ST_SUM)
                begin
                    // sums wrap at 64 bits, root lanes start empty
                    st_next[g].sq_rad  = st_reg[g-1].ssq[0] + st_reg[g-1].ssq[1] +
                                         st_reg[g-1].ssq[2];
                    st_next[g].rq_rad  = {32'b0, st_reg[g-1].rsq[0] + st_reg[g-1].rsq[1] +
                                         st_reg[g-1].rsq[2]};
                    st_next[g].sq_rem  = '0;
                    st_next[g].sq_root = '0;
                    st_next[g].rq_rem  = '0;
                    st_next[g].rq_root = '0;
                end
                else if (g >= ST_SQ0 && g < ST_SELECT)
                begin
                    st_next[g] = sqrt_step(st_reg[g-1]);
                end
                else if (g == ST_SELECT)
                begin
                    // cutoff, stretch and degenerate distance
                    st_next[g].broken = (cfg.cutoff != '0) &&
                                        (st_reg[g-1].sq_root > cfg.cutoff);
                    st_next[g].drneg = st_reg[g-1].sq_root < cfg.rest;
                    st_next[g].adr = st_next[g].drneg ? (cfg.rest - st_reg[g-1].sq_root)
                                                      : (st_reg[g-1].sq_root - cfg.rest);
                    st_next[g].force_on = st_next[g].adr > {16'b0, cfg.epsilon};
                    if (st_reg[g-1].sq_root <= {16'b0, cfg.epsilon})
                    begin
                        st_next[g].divisor = st_reg[g-1].rq_root;
                        st_next[g].dneg = st_reg[g-1].rneg;
                        for (int i = 0; i < 3; i++)
                        begin
                            st_next[g].dmag[i] = {16'b0, st_reg[g-1].rmag[i]};
                        end
                    end
                    else
                    begin
                        st_next[g].divisor = st_reg[g-1].sq_root;
                        st_next[g].dneg = st_reg[g-1].sneg;
                        st_next[g].dmag = st_reg[g-1].smag;
                    end
                end
                else if (g == ST_MUL)
                begin
                    st_next[g].num  = 64'(cfg.spring) * 64'(st_reg[g-1].adr);
                    st_next[g].adr2 = 64'(st_reg[g-1].adr) * 64'(st_reg[g-1].adr);
                end
                else if (g == ST_EMUL)
                begin
                    st_next[g].epl = 64'(cfg.spring) * 64'(st_reg[g-1].adr2[31:0]);
                    st_next[g].eph = 64'(cfg.spring) * 64'(st_reg[g-1].adr2[63:32]);
                end
                else if (g == ST_ECOMB)
                begin
                    // energy is the product shifted by twice the fraction plus one
                    acc = {32'b0, st_reg[g-1].epl} + {st_reg[g-1].eph, 32'b0};
                    st_next[g].esat = acc[95:2*FRAC_BITS+1+WORD_BITS] != '0;
                    st_next[g].energy = st_next[g].esat ? '1
                                      : acc[2*FRAC_BITS+1 +: WORD_BITS];
                    st_next[g].dv_rem = '0;
                end
                else if (g >= ST_DV0 && g < ST_FMUL)
                begin
                    st_next[g] = div_step(st_reg[g-1]);
                end
                else if (g == ST_FMUL)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        st_next[g].fpl[i] = 64'(st_reg[g-1].num[31:0]) *
                                            64'(st_reg[g-1].dmag[i]);
                        st_next[g].fph[i] = 64'(st_reg[g-1].num[63:32]) *
                                            64'(st_reg[g-1].dmag[i]);
                    end
                end
                else if (g == ST_FCOMB)
                begin
                    // force lanes with sign and clamp
                    sat = st_reg[g-1].esat;
                    for (int i = 0; i < 3; i++)
                    begin
                        acc = {32'b0, st_reg[g-1].fpl[i]} + {st_reg[g-1].fph[i], 32'b0};
                        pm = acc[95:FRAC_BITS];
                        fneg = st_reg[g-1].drneg ? st_reg[g-1].dneg[i]
                                                 : !st_reg[g-1].dneg[i];
                        if (pm == '0)
                        begin
                            fneg = 1'b0;
                        end
                        lim = fneg ? (80'd1 << (WORD_BITS-1))
                                   : ((80'd1 << (WORD_BITS-1)) - 80'd1);
                        m = pm[31:0];
                        if (!st_reg[g-1].force_on || st_reg[g-1].divisor == '0)
                        begin
                            st_next[g].force_v[i] = '0;
                        end
                        else
                        begin
                            if (pm > lim)
                            begin
                                m = lim[31:0];
                                sat = 1'b1;
                            end
                            st_next[g].force_v[i] = fneg ? (~m + 1'b1) : m;
                        end
                    end
                    st_next[g].fsat = sat;
                    if (st_reg[g-1].broken)
                    begin
                        st_next[g].force_v = '0;
                        st_next[g].energy = '0;
                        st_next[g].fsat = 1'b0;
                    end
                end
            end
        end
    end

    // pipe advances as one while the output word is free or taken
    assign en = !vld_reg[NST-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NST; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // output word
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata = {st_reg[NST-1].energy, st_reg[NST-1].force_v[2],
                      st_reg[NST-1].force_v[1], st_reg[NST-1].force_v[0]};
    assign m_tuser = {st_reg[NST-1].fsat, st_reg[NST-1].broken};

    // a broken bond carries no force, no energy and no clamp
    a_broken_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("broken bond word carries data");

    // an accepted word enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word lost at entry");

    // a stalled output freezes the whole pipe
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(vld_reg))
        else $error("pipe moved during stall");

    // input is refused only while the output word waits
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input refused without stall");

endmodule

`default_nettype wire

[bench/tb_harmonic_bond_force_energy_top.sv]
// testbench for the harmonic bond force and energy block, with a scoreboard class
`default_nettype none

module tb_harmonic_bond_force_energy_top
    import hbfe_pkg::*;
();

    localparam int LATENCY = 105;

    typedef struct {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        logic [31:0] energy;
        logic        status;
        logic        sat;
    } bond_word_t;

    // scoreboard with its own copy of the registers
    class bond_scoreboard;
        bond_word_t pending[$];
        int unsigned errors;
        logic [31:0] k_reg;
        logic [31:0] r_reg;
        logic [31:0] cut_reg;
        logic [15:0] eps_reg;

        function void reset_regs();
            k_reg = 32'h0001_0000;
            r_reg = 32'h0001_0000;
            cut_reg = '0;
            eps_reg = '0;
        endfunction

        function void set_reg(reg_index_t idx, logic [31:0] v);
            case (idx)
                REG_SPRING:  k_reg = v;
                REG_REST:    r_reg = v;
                REG_CUTOFF:  cut_reg = v;
                REG_EPSILON: eps_reg = v[15:0];
                default: ;
            endcase
        endfunction

        // truncated integer square root
        function logic [63:0] root64(logic [63:0] n);
            logic [63:0] res;
            logic [63:0] b;
            res = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end
                else res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        // bond force and energy for one separation word
        function bond_word_t bond_result(logic [143:0] d);
            bond_word_t w;
            logic [31:0] mag[3];
            logic neg[3];
            logic [63:0] sum, blen, adr, divisor, fac;
            logic [127:0] p, e;
            logic drneg, fneg;
            logic [31:0] lim, m, s;
            logic [15:0] rr;
            w = '{default: '0};
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                s = d[32*i +: 32];
                neg[i] = s[31];
                mag[i] = s[31] ? -s : s;
                sum = sum + 64'(mag[i]) * 64'(mag[i]);
            end
            blen = root64(sum);
            if (cut_reg != 0 && blen > 64'(cut_reg)) begin
                w.status = 1'b1;
                return w;
            end
            drneg = blen < 64'(r_reg);
            adr = drneg ? 64'(r_reg) - blen : blen - 64'(r_reg);
            if (adr > 64'(eps_reg)) begin
                divisor = blen;
                // degenerate distance: random vector stands in
                if (blen <= 64'(eps_reg)) begin
                    sum = 0;
                    for (int i = 0; i < 3; i++) begin
                        rr = d[96 + 16*i +: 16];
                        neg[i] = rr[15];
                        mag[i] = 32'(rr[15] ? 16'(-rr) : rr);
                        sum = sum + 64'(mag[i]) * 64'(mag[i]);
                    end
                    divisor = root64(sum);
                end
                if (divisor != 0) begin
                    fac = (64'(k_reg) * adr) / divisor;
                    for (int i = 0; i < 3; i++) begin
                        p = (128'(fac) * 128'(mag[i])) >> 16;
                        fneg = drneg ? neg[i] : !neg[i];
                        if (p == 0) fneg = 1'b0;
                        lim = fneg ? 32'h8000_0000 : 32'h7fff_ffff;
                        m = p[31:0];
                        if (p > 128'(lim)) begin
                            m = lim;
                            w.sat = 1'b1;
                        end
                        m = fneg ? -m : m;
                        if (i == 0) w.fx = m;
                        else if (i == 1) w.fy = m;
                        else w.fz = m;
                    end
                end
            end
            e = (128'(k_reg) * 128'(adr * adr)) >> 33;
            if (e > 128'hffff_ffff) begin
                w.energy = 32'hffff_ffff;
                w.sat = 1'b1;
            end
            else w.energy = e[31:0];
            return w;
        endfunction

        function void note_input(logic [143:0] d);
            pending.push_back(bond_result(d));
        endfunction

        function void check_result(logic [127:0] data, logic [1:0] user);
            bond_word_t x;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            x = pending.pop_front();
            if (data[31:0] !== x.fx) begin
                $error("force_x expected %h actual %h", x.fx, data[31:0]);
                errors++;
            end
            if (data[63:32] !== x.fy) begin
                $error("force_y expected %h actual %h", x.fy, data[63:32]);
                errors++;
            end
            if (data[95:64] !== x.fz) begin
                $error("force_z expected %h actual %h", x.fz, data[95:64]);
                errors++;
            end
            if (data[127:96] !== x.energy) begin
                $error("energy expected %h actual %h", x.energy, data[127:96]);
                errors++;
            end
            if (user[0] !== x.status) begin
                $error("status expected %b actual %b", x.status, user[0]);
                errors++;
            end
            if (user[1] !== x.sat) begin
                $error("saturated expected %b actual %b", x.sat, user[1]);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // sep_x, sep_y, sep_z (32 each), rand_x, rand_y, rand_z (16 each)
    logic [143:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // force_x, force_y, force_z, energy (32 each)
    logic [127:0] m_tdata;
    // status, saturated
    logic [1:0] m_tuser;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    bond_scoreboard sb = new();
    logic hold_off = 1'b0;

    harmonic_bond_force_energy_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

    // receiver: random stall pattern, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        m_tready <= !hold_off && (($urandom_range(0, 3) != 0) || (($urandom & 32'h40) != 0));
    end

    task automatic write_reg(reg_index_t idx, logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_BITS'(4 * int'(idx));
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // offer one word and wait for it to be taken
    task automatic send_word(logic [143:0] d);
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(d);
    endtask

    task automatic send_gap();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_comp(int unsigned scale);
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = 32'($urandom_range(0, 32'h0003_0000));
            2: v = -32'($urandom_range(0, 32'h0003_0000));
            3: v = 32'($urandom) >>> scale;
            default: v = 32'($urandom_range(0, 32'h0000_0100)) - 32'h80;
        endcase
        return v;
    endfunction

    function automatic logic [143:0] rand_word();
        logic [143:0] d;
        int unsigned sc;
        sc = $urandom_range(0, 16);
        d[31:0] = rand_comp(sc);
        d[63:32] = rand_comp(sc);
        d[95:64] = rand_comp(sc);
        d[143:96] = 48'({$urandom, $urandom});
        if ($urandom_range(0, 15) == 0) d[143:96] = '0;
        return d;
    endfunction

    task automatic random_phase(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && n > 0) begin
                send_word(rand_word());
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0) send_gap();
        end
    endtask

    initial
    begin
        logic [143:0] dir[$];
        sb.errors = 0;
        sb.reset_regs();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at reset settings
        dir.push_back('0);
        dir.push_back({16'h7fff, 16'h8000, 16'h1234, 32'h0, 32'h0, 32'h0});
        dir.push_back({48'h0, 32'h0, 32'h0, 32'h0001_0000});
        dir.push_back({48'h0, 32'h0, 32'h0, 32'h0002_0000});
        dir.push_back({48'h0, 32'h0, 32'h0, 32'hffff_0000});
        dir.push_back({48'h0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        dir.push_back({48'hffff_ffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        dir.push_back({48'h0, 32'h0, 32'h8000_0000, 32'h0});
        dir.push_back({48'h0, 32'h0003_0000, 32'hfffc_0000, 32'h0});
        foreach (dir[i]) send_word(dir[i]);
        drain();

        // extreme settings: large k, cutoff, epsilon
        write_reg(REG_SPRING, 32'hffff_ffff);
        write_reg(REG_REST, 32'h0);
        write_reg(REG_CUTOFF, 32'h0002_0000);
        write_reg(REG_EPSILON, 32'h0000_ffff);
        dir.delete();
        dir.push_back({16'h7fff, 16'h8000, 16'h4000, 32'h0, 32'h0, 32'h100});
        dir.push_back({48'h0, 32'h0, 32'h0, 32'h0});
        dir.push_back({48'h0, 32'h0, 32'h0, 32'h0001_8000});
        dir.push_back({48'h0, 32'h0, 32'h0, 32'h0002_0000});
        dir.push_back({48'h0, 32'h0, 32'h0, 32'h0002_0001});
        dir.push_back({48'h0, 32'h0, 32'h0, 32'h8000_0000});
        foreach (dir[i]) send_word(dir[i]);
        random_phase(150);
        drain();

        write_reg(REG_SPRING, 32'h0);
        write_reg(REG_REST, 32'hffff_ffff);
        write_reg(REG_CUTOFF, 32'hffff_ffff);
        write_reg(REG_EPSILON, 32'h0);
        random_phase(100);
        drain();

        write_reg(REG_SPRING, 32'h0010_0000);
        write_reg(REG_REST, 32'h0001_8000);
        write_reg(REG_CUTOFF, 32'h0);
        write_reg(REG_EPSILON, 32'h0000_0100);
        random_phase(150);

        // long receiver hold-off while words keep coming
        hold_off <= 1'b1;
        fork
            random_phase(200);
            begin
                repeat (300) @(posedge clk);
                hold_off <= 1'b0;
            end
        join
        drain();

        write_reg(REG_SPRING, $urandom);
        write_reg(REG_REST, $urandom_range(0, 32'h0004_0000));
        write_reg(REG_CUTOFF, $urandom_range(32'h0001_0000, 32'h0010_0000));
        write_reg(REG_EPSILON, {16'h0, 16'($urandom)});
        random_phase(285);
        drain();

        if (sb.errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hdl/hbfe_pkg.sv
hdl/hbfe_regs.sv
hdl/harmonic_bond_force_energy_top.sv
bench/tb_harmonic_bond_force_energy_top.sv
